@@ rtl/i8smx_pkg.sv @@
// Shared types, constants and arithmetic helpers of the int8 row softmax.
// Used by every module under rtl/ except i8smx_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package i8smx_pkg;

    localparam int ROW_MAX_DEF = 64;
    localparam int DIFF_W      = 9;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_CNT_W   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT     = 2'd0,
        CFG_SHIFT    = 2'd1,
        CFG_MIN_DIFF = 2'd2
    } i8smx_cfg_idx_t;

    localparam logic [30:0]        MULT_RST     = 31'd1073741824;
    localparam logic [4:0]         SHIFT_RST    = 5'd22;
    localparam logic signed [31:0] MIN_DIFF_RST = -32'sd255;

    localparam logic [31:0] EXP_C_THIRD = 32'd715827883;
    localparam logic [31:0] EXP_C_BASE  = 32'd1895147668;
    localparam logic [31:0] EXP_X_BIAS  = 32'h1000_0000;
    localparam logic [31:0] RECIP_SAT   = 32'h7FFF_FFFF;
    localparam logic [31:0] HALF_SCALE  = 32'h8000_0000;
    localparam logic [5:0]  SUM_SHIFT   = 6'd12;
    localparam logic [5:0]  ROUND_BASE  = 6'd35;
    localparam logic [5:0]  HEAD_EMPTY  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd62;
    localparam logic signed [7:0] PROB_MIN = -8'sd128;
    localparam logic signed [7:0] PROB_MAX = 8'sd127;
    localparam logic signed [32:0] PROB_OFFSET = 33'sd128;

    localparam logic [31:0] EXP_STEPS [7] = '{
        32'd1672461947, 32'd1302514674, 32'd790015084, 32'd290630308,
        32'd39332535, 32'd720401, 32'd242
    };

    localparam logic [3:0] OP_V     = 4'd0;
    localparam logic [3:0] OP_X2    = 4'd1;
    localparam logic [3:0] OP_QUAD  = 4'd2;
    localparam logic [3:0] OP_CUBE  = 4'd3;
    localparam logic [3:0] OP_POLY  = 4'd4;
    localparam logic [3:0] OP_BASE  = 4'd5;
    localparam logic [3:0] OP_STEP0 = 4'd6;
    localparam logic [3:0] OP_LAST  = 4'd12;

    typedef struct packed {
        logic signed [7:0] logit;
        logic              last_of_row;
    } i8smx_in_t;

    typedef struct packed {
        logic signed [7:0] probability;
        logic              last_out;
    } i8smx_out_t;

    typedef struct packed {
        logic [30:0]        multiplier;
        logic [4:0]         shift;
        logic signed [31:0] min_difference;
    } i8smx_cfg_t;

    typedef enum logic [1:0] {
        EXP_IDLE,
        EXP_MUL,
        EXP_USE
    } i8smx_exp_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SUM_RD,
        B_SUM_EX,
        B_SUM_WT,
        B_NORM,
        B_DIVSET,
        B_DIV,
        B_OUT_RD,
        B_OUT_EX,
        B_OUT_WT,
        B_OUT_RND,
        B_DONE
    } i8smx_back_state_t;

    function automatic logic [31:0] dbl_high(input logic signed [63:0] prod, input logic neg);
        logic signed [64:0] nudge;
        logic signed [64:0] s;
        logic signed [64:0] q;
        nudge = neg ? (65'sd1 - (65'sd1 <<< 30)) : (65'sd1 <<< 30);
        s = 65'(prod) + nudge;
        q = s[64] ? ((s + 65'sd2147483647) >>> 31) : (s >>> 31);
        return q[31:0];
    endfunction

    function automatic logic [31:0] round_shift(input logic [31:0] v, input logic [5:0] e);
        logic signed [39:0] t;
        logic signed [39:0] r;
        t = 40'($signed(v)) + (v[31] ? -40'sd1 : 40'sd0)
            + ((e == 6'd0) ? 40'sd0 : (40'sd1 <<< (e - 6'd1)));
        r = t >>> e;
        return (e == 6'd0) ? v : r[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/int8_softmax_row.sv @@
// Top level of the int8 row softmax: configuration registers, front part,
// row queue and back part. Depends on i8smx_pkg and all i8smx_* modules.
//
// Usage: drive item (logit, last_of_row) with start; an item is taken at a
// clock edge where start is high and busy is low. A row closes on last_of_row
// or when ROW_MAX logits have been taken. Once a row closes, the back part
// emits one result per logit on result, each for one cycle under
// result_valid, in row order, last_out high on the final one. The receiver
// cannot stall; results are never held back.
// After a row closes, the back part sums the exponentials of its logits,
// normalizes the sum, sets up and runs the division (skipped when the
// normalized sum is at most half scale), then emits the results; a skipped
// logit needs no exponential. The exponential unit has one shared
// multiplier and takes 13 multiplies per exponential; each kept logit
// needs two exponentials, one for the sum and one for its result.
// Two row banks let the front take the next row while the back works;
// busy rises only when both banks hold closed rows.
// Reset empties the queue and banks and loads the configuration defaults;
// cfg_we writes register cfg_index (0 multiplier, 1 shift, 2 min difference).
`timescale 1ns / 1ps
`default_nettype none

module int8_softmax_row #(
    parameter int ROW_MAX = i8smx_pkg::ROW_MAX_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire i8smx_pkg::i8smx_in_t                 item,
    output logic                                      result_valid,
    output i8smx_pkg::i8smx_out_t                     result,
    input  wire logic                                 cfg_we,
    input  wire logic [i8smx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [i8smx_pkg::CFG_W-1:0]          cfg_data
);
    import i8smx_pkg::*;

    localparam int IDX_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int CNT_W = $clog2(ROW_MAX + 1);

    i8smx_cfg_t          cfg_reg;
    i8smx_cfg_t          cfg_next;
    logic                accept;
    logic                push;
    logic [CNT_W+7:0]    push_data;
    logic                pop;
    logic [CNT_W+7:0]    head_data;
    logic                q_full;
    logic                q_empty;
    logic                wr_en;
    logic [IDX_W:0]      wr_addr;
    logic [7:0]          wr_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MULT:     cfg_next.multiplier     = cfg_data[30:0];
                CFG_SHIFT:    cfg_next.shift          = cfg_data[4:0];
                CFG_MIN_DIFF: cfg_next.min_difference = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multiplier     <= MULT_RST;
            cfg_reg.shift          <= SHIFT_RST;
            cfg_reg.min_difference <= MIN_DIFF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = start && !q_full;
    assign busy   = q_full;

    i8smx_front #(
        .ROW_MAX (ROW_MAX),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .push      (push),
        .push_data (push_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    i8smx_queue #(
        .DATA_W (CNT_W + 8)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    i8smx_back #(
        .ROW_MAX (ROW_MAX),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .q_empty      (q_empty),
        .q_data       (head_data),
        .q_pop        (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("row queue overrun");

    a_result_has_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !q_empty)
        else $error("result without a pending row");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_out) |=> !result_valid)
        else $error("result right after end of row");

endmodule

`default_nettype wire

@@ rtl/i8smx_queue.sv @@
// Two-entry row descriptor queue between the front and back parts.
// Depends on nothing beyond its DATA_W parameter.
`timescale 1ns / 1ps
`default_nettype none

module i8smx_queue #(
    parameter int DATA_W = 15
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      head_data,
    output logic                   full,
    output logic                   empty
);
    logic [DATA_W-1:0] entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign full      = fill_reg[1];
    assign empty     = (fill_reg == 2'd0);

endmodule

`default_nettype wire

@@ rtl/i8smx_front.sv @@
// Front part: accepts logits, writes them to the row bank, tracks the row maximum
// and pushes a row descriptor when the row closes. Depends on i8smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i8smx_front #(
    parameter int ROW_MAX = i8smx_pkg::ROW_MAX_DEF,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire i8smx_pkg::i8smx_in_t item,
    output logic                      push,
    output logic [CNT_W+7:0]          push_data,
    output logic                      wr_en,
    output logic [IDX_W:0]            wr_addr,
    output logic [7:0]                wr_data
);
    import i8smx_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [7:0]  max_reg;
    logic signed [7:0]  max_next;
    logic               bank_reg;
    logic               bank_next;
    logic [CNT_W-1:0]   count_inc;
    logic signed [7:0]  max_upd;
    logic               close;

    always_comb
    begin
        count_inc  = count_reg + CNT_W'(1);
        max_upd    = (item.logit > max_reg) ? item.logit : max_reg;
        close      = accept && (item.last_of_row || (count_inc == CNT_W'(ROW_MAX)));
        count_next = count_reg;
        max_next   = max_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            count_next = count_inc;
            max_next   = max_upd;
        end
        if (close)
        begin
            count_next = '0;
            max_next   = PROB_MIN;
            bank_next  = ~bank_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            max_reg   <= PROB_MIN;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            max_reg   <= max_next;
            bank_reg  <= bank_next;
        end
    end

    assign push      = close;
    assign push_data = {count_inc, max_upd};
    assign wr_en     = accept;
    assign wr_addr   = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data   = item.logit;

endmodule

`default_nettype wire

@@ rtl/i8smx_exp.sv @@
// Fixed-point exponential of a scaled non-positive difference on one shared
// multiplier. Depends on i8smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i8smx_exp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [8:0]     diff,
    input  wire i8smx_pkg::i8smx_cfg_t cfg,
    output logic                       done,
    output logic [31:0]                value
);
    import i8smx_pkg::*;

    i8smx_exp_state_t   state_reg;
    i8smx_exp_state_t   state_next;
    logic [3:0]         op_reg;
    logic [3:0]         op_next;
    logic               done_reg;
    logic               done_next;
    logic [31:0]        scaled_reg;
    logic [31:0]        scaled_next;
    logic [31:0]        x_reg;
    logic [31:0]        x_next;
    logic [31:0]        x2_reg;
    logic [31:0]        x2_next;
    logic [31:0]        t_reg;
    logic [31:0]        t_next;
    logic [31:0]        res_reg;
    logic [31:0]        res_next;
    logic [6:0]         rem_reg;
    logic [6:0]         rem_next;
    logic               vz_reg;
    logic               vz_next;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic               neg_reg;
    logic               neg_next;
    logic [31:0]        op_a;
    logic [31:0]        op_b;
    logic [31:0]        m;
    logic [31:0]        low;
    logic [31:0]        rem_full;
    logic [2:0]         step;
    logic [31:0]        stepped;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        done_next   = 1'b0;
        scaled_next = scaled_reg;
        x_next      = x_reg;
        x2_next     = x2_reg;
        t_next      = t_reg;
        res_next    = res_reg;
        rem_next    = rem_reg;
        vz_next     = vz_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        step        = 3'(op_reg - OP_STEP0);
        m           = dbl_high(prod_reg, neg_reg);
        low         = {8'hFF, m[23:0]};
        rem_full    = low - m;
        stepped     = rem_reg[step] ? m : res_reg;
        op_a        = res_reg;
        op_b        = EXP_STEPS[step];
        case (op_reg)
            OP_V:
            begin
                op_a = scaled_reg;
                op_b = {1'b0, cfg.multiplier};
            end
            OP_X2:
            begin
                op_a = x_reg;
                op_b = x_reg;
            end
            OP_QUAD:
            begin
                op_a = x2_reg;
                op_b = x2_reg;
            end
            OP_CUBE:
            begin
                op_a = x2_reg;
                op_b = x_reg;
            end
            OP_POLY:
            begin
                op_a = t_reg;
                op_b = EXP_C_THIRD;
            end
            OP_BASE:
            begin
                op_a = EXP_C_BASE;
                op_b = t_reg;
            end
            default:
            begin
                op_a = res_reg;
                op_b = EXP_STEPS[step];
            end
        endcase
        case (state_reg)
            EXP_IDLE:
            begin
                if (start)
                begin
                    scaled_next = 32'($signed(diff)) << cfg.shift;
                    op_next     = OP_V;
                    state_next  = EXP_MUL;
                end
            end
            EXP_MUL:
            begin
                prod_next  = $signed(op_a) * $signed(op_b);
                neg_next   = op_a[31] ^ op_b[31];
                state_next = EXP_USE;
            end
            EXP_USE:
            begin
                state_next = EXP_MUL;
                op_next    = op_reg + 4'd1;
                case (op_reg)
                    OP_V:
                    begin
                        rem_next = rem_full[30:24];
                        x_next   = (low << 5) + EXP_X_BIAS;
                        vz_next  = (m == 32'd0);
                    end
                    OP_X2:   x2_next  = m;
                    OP_QUAD: t_next   = round_shift(m, 6'd2);
                    OP_CUBE: t_next   = t_reg + m;
                    OP_POLY: t_next   = x_reg + round_shift(m + x2_reg, 6'd1);
                    OP_BASE: res_next = EXP_C_BASE + m;
                    default: res_next = stepped;
                endcase
                if (op_reg == OP_LAST)
                begin
                    res_next   = vz_reg ? RECIP_SAT : stepped;
                    done_next  = 1'b1;
                    state_next = EXP_IDLE;
                end
            end
            default: state_next = EXP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EXP_IDLE;
            op_reg    <= OP_V;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        res_reg    <= res_next;
        rem_reg    <= rem_next;
        vz_reg     <= vz_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
    end

    assign done  = done_reg;
    assign value = res_reg;

endmodule

`default_nettype wire

@@ rtl/i8smx_back.sv @@
// Back part: holds the two row banks, sums the exponentials of a closed row,
// normalizes and inverts the sum, then emits one probability per logit.
// Depends on i8smx_pkg and i8smx_exp.
`timescale 1ns / 1ps
`default_nettype none

module i8smx_back #(
    parameter int ROW_MAX = i8smx_pkg::ROW_MAX_DEF,
    parameter int IDX_W   = 6,
    parameter int CNT_W   = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire i8smx_pkg::i8smx_cfg_t cfg,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W:0]        wr_addr,
    input  wire logic [7:0]            wr_data,
    input  wire logic                  q_empty,
    input  wire logic [CNT_W+7:0]      q_data,
    output logic                       q_pop,
    output logic                       result_valid,
    output i8smx_pkg::i8smx_out_t      result
);
    import i8smx_pkg::*;

    localparam int DEPTH = 2 << IDX_W;

    logic [7:0] mem [DEPTH];

    i8smx_back_state_t   state_reg;
    i8smx_back_state_t   state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                bank_reg;
    logic                bank_next;
    logic [7:0]          rd_data_reg;
    logic [31:0]         sum_reg;
    logic [31:0]         sum_next;
    logic [31:0]         norm_reg;
    logic [31:0]         norm_next;
    logic [5:0]          head_reg;
    logic [5:0]          head_next;
    logic [62:0]         dvd_reg;
    logic [62:0]         dvd_next;
    logic [31:0]         rem_reg;
    logic [31:0]         rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [31:0]         scale_reg;
    logic [31:0]         scale_next;
    logic signed [63:0]  prod_reg;
    logic signed [63:0]  prod_next;
    logic                neg_reg;
    logic                neg_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    i8smx_out_t          res_reg;
    i8smx_out_t          res_next;

    logic [CNT_W-1:0]    row_count;
    logic signed [7:0]   row_max;
    logic signed [8:0]   diff;
    logic                keep;
    logic                last;
    logic                exp_start;
    logic                exp_done;
    logic [31:0]         exp_value;
    logic [32:0]         trial;
    logic                fits;
    logic [31:0]         rounded;
    logic signed [32:0]  shifted;
    logic [31:0]         sum_add;

    assign row_count = q_data[CNT_W+7:8];
    assign row_max   = q_data[7:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[{bank_reg, idx_reg}];
    end

    i8smx_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .diff  (diff),
        .cfg   (cfg),
        .done  (exp_done),
        .value (exp_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        bank_next      = bank_reg;
        sum_next       = sum_reg;
        norm_next      = norm_reg;
        head_next      = head_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        exp_start      = 1'b0;
        q_pop          = 1'b0;
        diff     = 9'($signed(rd_data_reg)) - 9'(row_max);
        keep     = 32'($signed(diff)) >= cfg.min_difference;
        last     = (CNT_W'(idx_reg) + CNT_W'(1)) == row_count;
        sum_add  = sum_reg + round_shift(exp_value, SUM_SHIFT);
        trial    = {rem_reg, dvd_reg[62]};
        fits     = trial >= {1'b0, norm_reg};
        rounded  = round_shift(dbl_high(prod_reg, neg_reg), ROUND_BASE - head_reg);
        shifted  = 33'($signed(rounded)) - PROB_OFFSET;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = B_SUM_RD;
                end
            end
            B_SUM_RD: state_next = B_SUM_EX;
            B_SUM_EX, B_SUM_WT:
            begin
                if (state_reg == B_SUM_EX && keep)
                begin
                    exp_start  = 1'b1;
                    state_next = B_SUM_WT;
                end
                else if (state_reg == B_SUM_EX || exp_done)
                begin
                    if (state_reg == B_SUM_WT)
                    begin
                        sum_next = sum_add;
                    end
                    if (last)
                    begin
                        norm_next  = sum_next;
                        head_next  = '0;
                        state_next = B_NORM;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = B_SUM_RD;
                    end
                end
            end
            B_NORM:
            begin
                if (sum_reg == 32'd0 || sum_reg[31])
                begin
                    head_next  = sum_reg[31] ? 6'd0 : HEAD_EMPTY;
                    norm_next  = '0;
                    state_next = B_DIVSET;
                end
                else if (norm_reg[31])
                begin
                    state_next = B_DIVSET;
                end
                else
                begin
                    norm_next = norm_reg << 1;
                    head_next = head_reg + 6'd1;
                end
            end
            B_DIVSET:
            begin
                idx_next = '0;
                if (norm_reg <= HALF_SCALE)
                begin
                    scale_next = RECIP_SAT;
                    state_next = B_OUT_RD;
                end
                else
                begin
                    dvd_next   = {1'b1, 31'd0, norm_reg[31:1]};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next = fits ? 32'(trial - {1'b0, norm_reg}) : trial[31:0];
                dvd_next = {dvd_reg[61:0], fits};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    scale_next = dvd_next[31:0];
                    state_next = B_OUT_RD;
                end
            end
            B_OUT_RD: state_next = B_OUT_EX;
            B_OUT_EX, B_OUT_WT, B_OUT_RND:
            begin
                if (state_reg == B_OUT_EX && keep)
                begin
                    exp_start  = 1'b1;
                    state_next = B_OUT_WT;
                end
                else if (state_reg == B_OUT_WT)
                begin
                    if (exp_done)
                    begin
                        prod_next  = $signed(scale_reg) * $signed(exp_value);
                        neg_next   = scale_reg[31] ^ exp_value[31];
                        state_next = B_OUT_RND;
                    end
                end
                else
                begin
                    res_valid_next   = 1'b1;
                    res_next.last_out = last;
                    if (state_reg == B_OUT_EX || shifted < 33'(PROB_MIN))
                    begin
                        res_next.probability = PROB_MIN;
                    end
                    else if (shifted > 33'(PROB_MAX))
                    begin
                        res_next.probability = PROB_MAX;
                    end
                    else
                    begin
                        res_next.probability = shifted[7:0];
                    end
                    if (last)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = B_OUT_RD;
                    end
                end
            end
            B_DONE:
            begin
                q_pop      = 1'b1;
                bank_next  = ~bank_reg;
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            bank_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            bank_reg      <= bank_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        norm_reg  <= norm_next;
        head_reg  <= head_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        scale_reg <= scale_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ tb/tb_int8_softmax_row.sv @@
// Self-checking testbench of int8_softmax_row: directed rows, then random rows
// under several configurations and idle patterns, checked by a bit-exact predictor.
// Depends on i8smx_pkg and the int8_softmax_row RTL.
`timescale 1ns / 1ps

module tb_int8_softmax_row;
    import i8smx_pkg::*;

    localparam int ROW_LEN     = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    i8smx_in_t              item;
    logic                   result_valid;
    i8smx_out_t             result;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int8_softmax_row #(.ROW_MAX(ROW_LEN)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result_valid(result_valid), .result(result), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // predictor state
    logic [30:0]        mult_reg;
    logic [4:0]         shift_reg;
    int                 min_diff_reg;
    logic signed [7:0]  row_buf [ROW_LEN];
    int                 row_len;
    int                 row_peak;
    i8smx_out_t         prob_q [$];

    int                 errors;
    int                 quiet_cycles;
    int                 idle_pct;
    int                 items_sent;

    function automatic int q31_mul(input int a, input int b);
        longint p;
        longint nudge;
        longint q;
        p = longint'(a) * longint'(b);
        nudge = ((a < 0) != (b < 0)) ? (64'sd1 - (64'sd1 <<< 30)) : (64'sd1 <<< 30);
        q = (p + nudge) / 64'sd2147483648;
        return int'(q);
    endfunction

    function automatic int rshift_round(input int v, input int e);
        longint t;
        longint r;
        if (e <= 0)
            return v;
        t = longint'(v) + ((v < 0) ? -64'sd1 : 64'sd0) + (64'sd1 <<< (e - 1));
        if (t >= 0)
            r = t >>> e;
        else
            r = -(((-t) + ((64'sd1 <<< e) - 64'sd1)) >>> e);
        return int'(r);
    endfunction

    function automatic int exp_of_neg(input int v);
        int lo;
        int x;
        int x2;
        int t1;
        int t2;
        int res;
        logic [31:0] rem;
        lo = int'((v & 32'h00FF_FFFF) - 32'h0100_0000);
        rem = lo - v;
        x = lo * 32 + (1 << 28);
        x2 = q31_mul(x, x);
        t1 = rshift_round(q31_mul(x2, x2), 2) + q31_mul(x2, x);
        t2 = x + rshift_round(q31_mul(t1, int'(EXP_C_THIRD)) + x2, 1);
        res = int'(EXP_C_BASE) + q31_mul(int'(EXP_C_BASE), t2);
        for (int k = 0; k < 7; k++)
            if (rem[24 + k])
                res = q31_mul(res, int'(EXP_STEPS[k]));
        if (v == 0)
            res = int'(RECIP_SAT);
        return res;
    endfunction

    function automatic int recip_norm(input int v);
        longint s;
        longint unsigned num;
        s = longint'(v) + 64'sd2147483648;
        if (s <= 64'sd2147483648)
            return int'(RECIP_SAT);
        num = (64'd1 << 62) + longint'(s >>> 1);
        return int'(num / longint'(s));
    endfunction

    function automatic int clz32(input logic [31:0] u);
        for (int i = 31; i >= 0; i--)
            if (u[i])
                return 31 - i;
        return 32;
    endfunction

    function automatic int exp_of_diff(input int d);
        logic [31:0] factor;
        int scaled;
        factor = 32'd1 << shift_reg;
        scaled = int'(d * factor);
        return exp_of_neg(q31_mul(scaled, int'({1'b0, mult_reg})));
    endfunction

    function automatic void softmax_close();
        int sum;
        int head;
        int scale;
        int d;
        longint r;
        logic [31:0] nrm;
        i8smx_out_t o;
        sum = 0;
        for (int i = 0; i < row_len; i++)
        begin
            d = int'(row_buf[i]) - row_peak;
            if (d >= min_diff_reg)
                sum = sum + rshift_round(exp_of_diff(d), 12);
        end
        head = clz32(sum);
        nrm = (sum > 0) ? (32'(sum) << head) : 32'd0;
        scale = recip_norm(int'(nrm - 32'h8000_0000));
        for (int i = 0; i < row_len; i++)
        begin
            d = int'(row_buf[i]) - row_peak;
            r = -128;
            if (d >= min_diff_reg)
            begin
                r = longint'(rshift_round(q31_mul(scale, exp_of_diff(d)), 35 - head)) - 128;
                if (r < -128)
                    r = -128;
                if (r > 127)
                    r = 127;
            end
            o.probability = 8'(r);
            o.last_out = (i + 1 == row_len);
            prob_q.push_back(o);
        end
        row_len = 0;
        row_peak = -128;
    endfunction

    function automatic void softmax_take(input logic signed [7:0] lg, input logic lst);
        if (row_len < ROW_LEN)
        begin
            row_buf[row_len] = lg;
            row_len++;
        end
        if (int'(lg) > row_peak)
            row_peak = int'(lg);
        if (lst || row_len >= ROW_LEN)
            softmax_close();
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_logit(input logic signed [7:0] lg, input logic lst);
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        start = 1'b1;
        item.logit = lg;
        item.last_of_row = lst;
        do
            @(posedge clk);
        while (busy);
        softmax_take(lg, lst);
        items_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_reg(input i8smx_cfg_idx_t idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            CFG_MULT:     mult_reg = val[30:0];
            CFG_SHIFT:    shift_reg = val[4:0];
            default:      min_diff_reg = int'(val);
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (prob_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        i8smx_out_t want;
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (result_valid)
            begin
                if (prob_q.size() == 0)
                begin
                    $error("probability: no item expected, actual %0d", result.probability);
                    errors++;
                end
                else
                begin
                    want = prob_q.pop_front();
                    if (result.probability !== want.probability)
                    begin
                        $error("probability: expected %0d actual %0d",
                               want.probability, result.probability);
                        errors++;
                    end
                    if (result.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0d actual %0d",
                               want.last_out, result.last_out);
                        errors++;
                    end
                end
            end
        end
    end

    typedef struct {
        logic signed [7:0] lg;
        logic              lst;
        bit                typed;
        logic signed [7:0] want;
    } dir_row_t;

    localparam int DIR_N   = 13;
    localparam int SKIP_AT = 10;

    dir_row_t dir_tab [DIR_N] = '{
        '{8'sd0,    1'b1, 1'b1, 8'sd127},
        '{-8'sd128, 1'b1, 1'b1, 8'sd127},
        '{8'sd127,  1'b0, 1'b0, 8'sd0},
        '{-8'sd128, 1'b0, 1'b0, 8'sd0},
        '{8'sd0,    1'b0, 1'b0, 8'sd0},
        '{-8'sd1,   1'b0, 1'b0, 8'sd0},
        '{8'sd85,   1'b0, 1'b0, 8'sd0},
        '{-8'sd86,  1'b1, 1'b0, 8'sd0},
        '{8'sd120,  1'b0, 1'b0, 8'sd0},
        '{8'sd127,  1'b1, 1'b0, 8'sd0},
        '{8'sd5,    1'b1, 1'b1, -8'sd128},
        '{-8'sd128, 1'b0, 1'b0, 8'sd0},
        '{8'sd127,  1'b1, 1'b0, 8'sd0}
    };

    initial
    begin
        logic [30:0] cfg_mult [5];
        logic [31:0] cfg_shift [5];
        logic [31:0] cfg_min [5];
        int len;
        int center;
        int spread;
        int lg;
        int target;
        errors = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        items_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MULT;
        cfg_data = '0;
        mult_reg = MULT_RST;
        shift_reg = SHIFT_RST;
        min_diff_reg = int'(MIN_DIFF_RST);
        row_len = 0;
        row_peak = -128;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            if (i == SKIP_AT)
            begin
                drain();
                write_reg(CFG_MIN_DIFF, 32'd1);
            end
            send_logit(dir_tab[i].lg, dir_tab[i].lst);
            if (dir_tab[i].typed)
                prob_q[$].probability = dir_tab[i].want;
        end

        cfg_mult  = '{31'd1073741824, 31'h7FFF_FFFF, 31'd0, 31'($urandom), 31'd1};
        cfg_shift = '{32'd22, 32'd30, 32'd0, 32'($urandom_range(31)), 32'd31};
        cfg_min   = '{32'hFFFF_FF01, 32'h8000_0000, 32'd0,
                      32'(-int'($urandom_range(300))), 32'hFFFF_FFFF};

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_reg(CFG_MULT, {1'b0, cfg_mult[ph]});
            write_reg(CFG_SHIFT, cfg_shift[ph]);
            write_reg(CFG_MIN_DIFF, cfg_min[ph]);
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 81;
                2: idle_pct = 0;
                default: idle_pct = 17;
            endcase
            target = items_sent + 30;
            while (items_sent < target)
            begin
                case ($urandom_range(19))
                    0: len = $urandom_range(70, 64);
                    1, 2: len = $urandom_range(20, 9);
                    default: len = $urandom_range(8, 1);
                endcase
                if (ph == 0 && items_sent < target - 26)
                    len = 66;
                center = $urandom_range(255) - 128;
                spread = ($urandom_range(3) == 0) ? 255 : $urandom_range(40);
                for (int j = 0; j < len; j++)
                begin
                    lg = center + $urandom_range(2 * spread) - spread;
                    if ($urandom_range(9) == 0)
                        lg = $urandom_range(255) - 128;
                    if (lg > 127)
                        lg = 127;
                    if (lg < -128)
                        lg = -128;
                    send_logit(8'(lg), j == len - 1);
                end
            end
        end

        drain();
        if (errors == 0 && prob_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/i8smx_pkg.sv
rtl/i8smx_queue.sv
rtl/i8smx_front.sv
rtl/i8smx_exp.sv
rtl/i8smx_back.sv
rtl/int8_softmax_row.sv
tb/tb_int8_softmax_row.sv
